// File: sv/nms_pkg.sv
`timescale 1ns / 1ps

package nms_pkg;

   localparam int SIZE_DEF = 3;
   localparam int ELEM_W   = 16;
   // eight 16-bit values summed
   localparam int SUM_W    = 19;
   localparam int CNT_W    = 4;
   localparam int NB_W     = 3;

   localparam logic [CNT_W-1:0] CNT_CORNER = 4'd3;
   localparam logic [CNT_W-1:0] CNT_EDGE   = 4'd5;
   localparam logic [CNT_W-1:0] CNT_INNER  = 4'd8;

   // floor(2^24 / d) for the doubled divisors 6 and 10
   localparam int          RECIP_SHIFT = 24;
   localparam int          RECIP_W     = 22;
   localparam logic [21:0] RECIP_6     = 22'd2796202;
   localparam logic [21:0] RECIP_10    = 22'd1677721;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } nb_dir_type;

   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        cnt;
   } div_req_type;

   // direction of neighbour idx around the center
   function automatic nb_dir_type nb_dir(input logic [NB_W-1:0] idx);
      nb_dir_type d;
      d = '0;
      case (idx)
         3'd0: begin
            d.up   = 1'b1;
            d.left = 1'b1;
         end
         3'd1: d.up = 1'b1;
         3'd2: begin
            d.up    = 1'b1;
            d.right = 1'b1;
         end
         3'd3: d.left  = 1'b1;
         3'd4: d.right = 1'b1;
         3'd5: begin
            d.down = 1'b1;
            d.left = 1'b1;
         end
         3'd6: d.down = 1'b1;
         3'd7: begin
            d.down  = 1'b1;
            d.right = 1'b1;
         end
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// File: sv/nms_ram.sv
`timescale 1ns / 1ps

module nms_ram #(
   parameter int WIDTH = nms_pkg::ELEM_W,
   parameter int DEPTH = nms_pkg::SIZE_DEF * nms_pkg::SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/nms_div.sv
`timescale 1ns / 1ps

// Rounded mean: q = (2|s| + c) / (2c), sign restored. Two register stages.
module nms_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nms_pkg::div_req_type                  req,
   output logic                                  res_valid,
   output logic signed [nms_pkg::ELEM_W-1:0]     res_mean
);

   localparam int N_W = nms_pkg::SUM_W + 1;
   localparam int Q_W = 17;
   localparam int P_W = N_W + nms_pkg::RECIP_W;
   localparam int R_W = Q_W + 5;

   logic [nms_pkg::SUM_W:0]   sum_ext;
   logic [nms_pkg::SUM_W:0]   mag;
   logic [N_W-1:0]            n_in;

   logic                      v1_ff, v2_ff;
   logic                      neg1_ff, neg2_ff;
   logic [N_W-1:0]            n1_ff, n2_ff;
   logic [nms_pkg::CNT_W-1:0] cnt1_ff, cnt2_ff;
   logic [Q_W-1:0]            q2_ff;

   logic [nms_pkg::RECIP_W-1:0] recip;
   logic [P_W-1:0]              prod;
   logic [Q_W-1:0]              q_in;

   logic [4:0]     div_d;
   logic [R_W-1:0] qd;
   logic [R_W-1:0] rem;
   logic [Q_W-1:0] q_fix;
   logic [Q_W-1:0] q_sgn;

   // stage 1: magnitude and rounding numerator
   always_comb begin
      sum_ext = {req.sum[nms_pkg::SUM_W-1], req.sum};
      mag     = req.sum[nms_pkg::SUM_W-1] ? (~sum_ext + 1'b1) : sum_ext;
      n_in    = {mag[nms_pkg::SUM_W-1:0], 1'b0} + N_W'(req.cnt);
   end

   // stage 2: reciprocal multiply, estimate may be one low
   always_comb begin
      case (cnt1_ff)
         nms_pkg::CNT_CORNER: recip = nms_pkg::RECIP_6;
         nms_pkg::CNT_EDGE:   recip = nms_pkg::RECIP_10;
         default:             recip = '0;
      endcase
      prod = P_W'(n1_ff) * P_W'(recip);
      if (cnt1_ff == nms_pkg::CNT_INNER) begin
         q_in = Q_W'(n1_ff >> 4);
      end else begin
         q_in = prod[nms_pkg::RECIP_SHIFT +: Q_W];
      end
   end

   // output: one correction step, then sign
   always_comb begin
      case (cnt2_ff)
         nms_pkg::CNT_CORNER: div_d = 5'd6;
         nms_pkg::CNT_EDGE:   div_d = 5'd10;
         default:             div_d = 5'd16;
      endcase
      qd       = R_W'(q2_ff) * R_W'(div_d);
      rem      = R_W'(n2_ff) - qd;
      q_fix    = q2_ff + Q_W'(rem >= R_W'(div_d));
      q_sgn    = neg2_ff ? (~q_fix + 1'b1) : q_fix;
      res_mean = q_sgn[nms_pkg::ELEM_W-1:0];
   end

   assign res_valid = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff | (v2_ff & ~req.valid);
      end
      if (req.valid) begin
         neg1_ff <= req.sum[nms_pkg::SUM_W-1];
         n1_ff   <= n_in;
         cnt1_ff <= req.cnt;
      end
      if (v1_ff) begin
         neg2_ff <= neg1_ff;
         n2_ff   <= n1_ff;
         cnt2_ff <= cnt1_ff;
         q2_ff   <= q_in;
      end
   end

endmodule

// File: sv/neighbour_mean_smoothing_top.sv
// Eight-neighbour mean smoothing. Feed a SIZE x SIZE matrix of signed 16-bit
// elements in row-major order on req_*, one per cycle while req_tready is
// high. After the last element the block emits SIZE*SIZE results on rsp_*,
// row-major, each the mean of the existing neighbours of that position
// (3 at a corner, 5 on an edge, 8 inside), center excluded, rounded to
// nearest with halves away from zero; rsp_tlast marks the final result.
// Loading runs at one element per cycle. Each result is then produced by eight
// reads of the matrix RAM through its single read port, the registered read,
// and the two-stage rounding divide, and goes out when the output is free.
// The next matrix may load while the final result still waits in the output
// register. The matrix RAM needs no clearing after reset.
`timescale 1ns / 1ps

module neighbour_mean_smoothing_top #(
   parameter int SIZE = nms_pkg::SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] smoothed
   output logic        rsp_tlast    // last_result
);

   localparam int CELLS = SIZE * SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(SIZE);

   localparam logic [AW-1:0] SIZE_A    = AW'(SIZE);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(SIZE - 1);
   localparam logic [nms_pkg::NB_W-1:0] NB_LAST = '1;

   typedef enum logic [2:0] {
      S_LOAD,   // taking matrix elements
      S_WALK,   // issuing one neighbour read per cycle
      S_TAIL,   // last read data lands in the accumulator
      S_DIV,    // sum and count handed to the divider
      S_WAIT    // waiting for the quotient and a free output slot
   } state_type;

   state_type                   state_ff;
   logic [AW-1:0]               load_cnt_ff;
   logic [IW-1:0]               row_ff, col_ff;
   logic [AW-1:0]               pos_ff;
   logic [nms_pkg::NB_W-1:0]    nb_ff;
   logic                        rd_ok_ff;
   logic signed [nms_pkg::SUM_W-1:0] sum_ff;
   logic [nms_pkg::CNT_W-1:0]   cnt_ff;
   logic                        rsp_tvalid_ff;
   logic [15:0]                 rsp_data_ff;
   logic                        rsp_last_ff;

   logic                        req_fire;
   logic                        out_free;
   logic                        emit;
   nms_pkg::nb_dir_type         dir;
   logic                        nb_ok;
   logic [AW-1:0]               rd_addr;
   logic [nms_pkg::ELEM_W-1:0]  rd_data;
   logic [nms_pkg::SUM_W-1:0]   rd_ext;
   nms_pkg::div_req_type        div_req;
   logic                        res_valid;
   logic signed [nms_pkg::ELEM_W-1:0] res_mean;

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign emit       = (state_ff == S_WAIT) && res_valid && out_free;

   // neighbour address and border check
   always_comb begin
      dir   = nms_pkg::nb_dir(nb_ff);
      nb_ok = !(dir.up    && (row_ff == '0))       &&
              !(dir.down  && (row_ff == LAST_IDX)) &&
              !(dir.left  && (col_ff == '0))       &&
              !(dir.right && (col_ff == LAST_IDX));
      // modular arithmetic is exact whenever nb_ok holds
      rd_addr = pos_ff;
      if (dir.up) begin
         rd_addr = rd_addr - SIZE_A;
      end
      if (dir.down) begin
         rd_addr = rd_addr + SIZE_A;
      end
      if (dir.left) begin
         rd_addr = rd_addr - AW'(1);
      end
      if (dir.right) begin
         rd_addr = rd_addr + AW'(1);
      end
      rd_ext = {{(nms_pkg::SUM_W - nms_pkg::ELEM_W){rd_data[nms_pkg::ELEM_W-1]}}, rd_data};
   end

   always_comb begin
      div_req.valid = (state_ff == S_DIV);
      div_req.sum   = sum_ff;
      div_req.cnt   = cnt_ff;
   end

   nms_ram #(
      .WIDTH (nms_pkg::ELEM_W),
      .DEPTH (CELLS)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (load_cnt_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nms_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .res_valid (res_valid),
      .res_mean  (res_mean)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         load_cnt_ff   <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         pos_ff        <= '0;
         nb_ff         <= '0;
         rd_ok_ff      <= 1'b0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rd_ok_ff <= (state_ff == S_WALK) && nb_ok;
         if (rd_ok_ff) begin
            sum_ff <= sum_ff + $signed(rd_ext);
            cnt_ff <= cnt_ff + 1'b1;
         end
         // a new result reloads the slot in the same cycle it drains
         if (rsp_tvalid_ff && rsp_tready && !emit) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_LOAD: begin
               if (req_fire) begin
                  if (load_cnt_ff == LAST_CELL) begin
                     load_cnt_ff <= '0;
                     sum_ff      <= '0;
                     cnt_ff      <= '0;
                     state_ff    <= S_WALK;
                  end else begin
                     load_cnt_ff <= load_cnt_ff + 1'b1;
                  end
               end
            end
            S_WALK: begin
               nb_ff <= nb_ff + 1'b1;
               if (nb_ff == NB_LAST) begin
                  state_ff <= S_TAIL;
               end
            end
            S_TAIL: state_ff <= S_DIV;
            S_DIV:  state_ff <= S_WAIT;
            S_WAIT: begin
               if (emit) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= res_mean;
                  rsp_last_ff   <= (pos_ff == LAST_CELL);
                  sum_ff        <= '0;
                  cnt_ff        <= '0;
                  if (pos_ff == LAST_CELL) begin
                     pos_ff   <= '0;
                     row_ff   <= '0;
                     col_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     pos_ff <= pos_ff + 1'b1;
                     if (col_ff == LAST_IDX) begin
                        col_ff <= '0;
                        row_ff <= row_ff + 1'b1;
                     end else begin
                        col_ff <= col_ff + 1'b1;
                     end
                     state_ff <= S_WALK;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   // every position has a corner, edge or interior neighbour count
   a_cnt_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (cnt_ff == nms_pkg::CNT_CORNER ||
                             cnt_ff == nms_pkg::CNT_EDGE   ||
                             cnt_ff == nms_pkg::CNT_INNER))
      else $error("neighbour count wrong at divide");

   // read data only accumulates right after a walk cycle
   a_rd_window: assert property (@(posedge clock) disable iff (reset)
      rd_ok_ff |-> (state_ff == S_WALK || state_ff == S_TAIL))
      else $error("neighbour read outside walk");

   // load pointer rests at zero while results are produced
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_LOAD |-> load_cnt_ff == '0)
      else $error("load pointer moved during smoothing");

   // final result goes out with tlast and reopens loading
   a_last_out: assert property (@(posedge clock) disable iff (reset)
      emit && (pos_ff == LAST_CELL) |=> rsp_tvalid && rsp_tlast && req_tready)
      else $error("final result not flagged or load not reopened");

endmodule
